### sv/pdb_pkg.sv
package pdb_pkg;

  // angle units: 1e-12 degree
  localparam int CORDIC_STEPS = 44;
  localparam int VAL_W        = 48;
  localparam int QUO_W        = 7;
  localparam int DIST_W       = 17;
  localparam int BRG_W        = 9;
  localparam int NORM_MSB     = 57;
  localparam int SHIFT_W      = 6;

  localparam logic [VAL_W-1:0] ANG_ONE_DEG  = 48'd1000000000000;
  localparam logic [VAL_W-1:0] ANG_HALF_DEG = 48'd500000000000;
  localparam logic [VAL_W-1:0] ANG_90_DEG   = 48'd90000000000000;
  localparam longint unsigned  DEG_PER_RAD_FEMTO = 64'd57295779513082321;

  localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;

  localparam logic [BRG_W-1:0] BRG_UP    = 9'd0;
  localparam logic [BRG_W-1:0] BRG_RIGHT = 9'd90;
  localparam logic [BRG_W-1:0] BRG_DOWN  = 9'd180;
  localparam logic [BRG_W-1:0] BRG_LEFT  = 9'd270;
  localparam logic [BRG_W-1:0] BRG_FULL  = 9'd360;

  // sign and zero flags of the difference vector
  typedef struct packed {
    logic dx_zero;
    logic dy_zero;
    logic dx_neg;
    logic dy_neg;
  } quad_t;

  // v / (2k + 1) for series term k
  function automatic longint unsigned div_odd(longint unsigned v, int k);
    case (k)
      0:  return v;
      1:  return v / 64'd3;
      2:  return v / 64'd5;
      3:  return v / 64'd7;
      4:  return v / 64'd9;
      5:  return v / 64'd11;
      6:  return v / 64'd13;
      7:  return v / 64'd15;
      8:  return v / 64'd17;
      9:  return v / 64'd19;
      10: return v / 64'd21;
      11: return v / 64'd23;
      12: return v / 64'd25;
      13: return v / 64'd27;
      14: return v / 64'd29;
      15: return v / 64'd31;
      16: return v / 64'd33;
      17: return v / 64'd35;
      18: return v / 64'd37;
      19: return v / 64'd39;
      20: return v / 64'd41;
      21: return v / 64'd43;
      22: return v / 64'd45;
      23: return v / 64'd47;
      24: return v / 64'd49;
      25: return v / 64'd51;
      26: return v / 64'd53;
      27: return v / 64'd55;
      28: return v / 64'd57;
      29: return v / 64'd59;
      30: return v / 64'd61;
      31: return v / 64'd63;
      default: return 64'd0;
    endcase
  endfunction

  // atan(2^-i) in 1e-12 degree, alternating series, evaluated at elaboration
  function automatic longint atan_step(int i);
    longint unsigned base;
    longint unsigned t;
    longint          acc;
    int              sh;
    logic            done;
    acc  = 0;
    done = 1'b0;
    base = DEG_PER_RAD_FEMTO >> i;
    if (i == 0) return 64'sd45000000000000;
    for (int k = 0; k < 32; k++) begin
      sh = 2 * i * k;
      if (!done) begin
        if (sh >= 64) begin
          done = 1'b1;
        end else begin
          t = div_odd(base >> sh, k);
          if (t == 0) begin
            done = 1'b1;
          end else if ((k & 1) != 0) begin
            acc = acc - longint'(t);
          end else begin
            acc = acc + longint'(t);
          end
        end
      end
    end
    return (acc + 500) / 1000;
  endfunction

endpackage

### sv/pdb_if.sv
interface pdb_in_if #(
  parameter int CW = 16
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] from_x;
  logic signed [CW-1:0] from_y;
  logic signed [CW-1:0] to_x;
  logic signed [CW-1:0] to_y;

  modport source(output valid, output from_x, output from_y, output to_x, output to_y,
                 input ready);
  modport sink(input valid, input from_x, input from_y, input to_x, input to_y,
               output ready);
endinterface

interface pdb_out_if import pdb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] dist_res;
  logic [BRG_W-1:0]  bearing_deg;

  modport source(output valid, output dist_res, output bearing_deg, input ready);
  modport sink(input valid, input dist_res, input bearing_deg, output ready);
endinterface

### sv/point_distance_and_bearing.sv
// stage chain: diff, abs, square, sum, norm, cordic, clamp, divide, output
// throughput: one word per cycle; the whole pipe advances whenever the output
// register is empty or taken, so a stall holds every stage in place
// 44 cordic stages (the isqrt steps ride along in the same stages) set the depth
// reset (rst_n low, synchronous) clears all stage valid bits; data regs keep junk
module point_distance_and_bearing import pdb_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  pdb_in_if.sink       in_pt,
  pdb_out_if.source    out_res
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int SQW = 2 * DW;
  localparam int NIT = CORDIC_STEPS;

  logic adv;
  logic out_v_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [BRG_W-1:0]  out_brg_r;

  // whole pipe moves when the output slot frees up
  assign adv         = !out_v_r || out_res.ready;
  assign in_pt.ready = adv;

  // stage 0: differences
  logic                 v0_r;
  logic signed [DW-1:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r <= {in_pt.to_x[COORD_WIDTH-1], in_pt.to_x}
            - {in_pt.from_x[COORD_WIDTH-1], in_pt.from_x};
      dy_r <= {in_pt.to_y[COORD_WIDTH-1], in_pt.to_y}
            - {in_pt.from_y[COORD_WIDTH-1], in_pt.from_y};
    end
  end

  // stage 1: magnitudes and quadrant flags
  logic          v1_r;
  logic [DW-1:0] ax_r, ay_r;
  quad_t         q1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r <= dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
      ay_r <= dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
      q1_r <= '{dx_zero: (dx_r == '0), dy_zero: (dy_r == '0),
                dx_neg: dx_r[DW-1], dy_neg: dy_r[DW-1]};
    end
  end

  // stage 2: squares and larger magnitude
  logic           v2_r;
  logic [SQW-1:0] sqx_r, sqy_r;
  logic [DW-1:0]  mx_r, ax2_r, ay2_r;
  quad_t          q2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r <= SQW'(ax_r) * SQW'(ax_r);
      sqy_r <= SQW'(ay_r) * SQW'(ay_r);
      mx_r  <= (ax_r > ay_r) ? ax_r : ay_r;
      ax2_r <= ax_r;
      ay2_r <= ay_r;
      q2_r  <= q1_r;
    end
  end

  // stage 3: sum of squares and leading one of the larger magnitude
  logic               v3_r;
  logic [SQW-1:0]     sum_r;
  logic [SHIFT_W-1:0] msb_r;
  logic [SHIFT_W-1:0] msb;
  logic [DW-1:0]      ax3_r, ay3_r;
  quad_t              q3_r;

  always_comb begin
    msb = '0;
    for (int j = 0; j < DW; j++) begin
      if (mx_r[j]) msb = SHIFT_W'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sqx_r + sqy_r;
      msb_r <= msb;
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      q3_r  <= q2_r;
    end
  end

  // iteration stages: index 0 is the normalized start, index NIT the end
  logic                 iv_r  [NIT+1];
  logic signed [63:0]   cx_r  [NIT+1];
  logic signed [63:0]   cy_r  [NIT+1];
  logic signed [63:0]   cz_r  [NIT+1];
  logic [SQW-1:0]       sn_r  [NIT+1];
  logic [SQW-1:0]       sr_r  [NIT+1];
  quad_t                ifl_r [NIT+1];
  logic [SHIFT_W-1:0]   nsh;

  assign nsh = SHIFT_W'(NORM_MSB) - msb_r;

  // stage 4: normalize so the larger coordinate has its top bit at NORM_MSB
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r[0] <= 1'b0;
    end else if (adv) begin
      iv_r[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0]  <= $signed(64'(ay3_r) << nsh);
      cy_r[0]  <= $signed(64'(ax3_r) << nsh);
      cz_r[0]  <= '0;
      sn_r[0]  <= sum_r;
      sr_r[0]  <= '0;
      ifl_r[0] <= q3_r;
    end
  end

  for (genvar i = 0; i < NIT; i++) begin : g_iter
    localparam logic signed [63:0] ANG_STEP = 64'(atan_step(i));
    logic signed [63:0] xs, ys, x_nxt, y_nxt, z_nxt;
    logic [SQW-1:0]     n_nxt, r_nxt;

    // one cordic vectoring step
    always_comb begin
      xs = cx_r[i] >>> i;
      ys = cy_r[i] >>> i;
      if (!cy_r[i][63]) begin
        x_nxt = cx_r[i] + ys;
        y_nxt = cy_r[i] - xs;
        z_nxt = cz_r[i] + ANG_STEP;
      end else begin
        x_nxt = cx_r[i] - ys;
        y_nxt = cy_r[i] + xs;
        z_nxt = cz_r[i] - ANG_STEP;
      end
    end

    // one bit pair of the integer square root
    if (i < DW) begin : g_sqrt
      localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * i);
      logic [SQW:0] trial;
      always_comb begin
        trial = {1'b0, sr_r[i]} + {1'b0, BIT};
        if ({1'b0, sn_r[i]} >= trial) begin
          n_nxt = sn_r[i] - trial[SQW-1:0];
          r_nxt = (sr_r[i] >> 1) + BIT;
        end else begin
          n_nxt = sn_r[i];
          r_nxt = sr_r[i] >> 1;
        end
      end
    end else begin : g_hold
      assign n_nxt = sn_r[i];
      assign r_nxt = sr_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        iv_r[i+1] <= 1'b0;
      end else if (adv) begin
        iv_r[i+1] <= iv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cx_r[i+1]  <= x_nxt;
        cy_r[i+1]  <= y_nxt;
        cz_r[i+1]  <= z_nxt;
        sn_r[i+1]  <= n_nxt;
        sr_r[i+1]  <= r_nxt;
        ifl_r[i+1] <= ifl_r[i];
      end
    end
  end

  // clamp stage, then restoring divide by one degree, one quotient bit a stage
  logic               dv_r  [QUO_W+1];
  logic [VAL_W-1:0]   rem_r [QUO_W+1];
  logic [QUO_W-1:0]   quo_r [QUO_W+1];
  logic [DIST_W-1:0]  dd_r  [QUO_W+1];
  quad_t              dfl_r [QUO_W+1];

  logic signed [63:0] zend;
  logic [VAL_W-1:0]   zclamp;
  logic [SQW-1:0]     root_rnd;
  logic [DIST_W-1:0]  dist_sat;

  always_comb begin
    zend = cz_r[NIT];
    if (zend[63]) begin
      zclamp = '0;
    end else if (zend > $signed({16'd0, ANG_90_DEG})) begin
      zclamp = ANG_90_DEG;
    end else begin
      zclamp = zend[VAL_W-1:0];
    end
    // round root up when the remainder exceeds it
    root_rnd = sr_r[NIT] + SQW'(sn_r[NIT] > sr_r[NIT]);
    dist_sat = (root_rnd > SQW'(DIST_MAX)) ? DIST_MAX : root_rnd[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= iv_r[NIT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= zclamp + ANG_HALF_DEG;
      quo_r[0] <= '0;
      dd_r[0]  <= dist_sat;
      dfl_r[0] <= ifl_r[NIT];
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int K = QUO_W - 1 - j;
    localparam logic [VAL_W-1:0] THR = ANG_ONE_DEG << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_r[j] >= THR) begin
          rem_r[j+1] <= rem_r[j] - THR;
          quo_r[j+1] <= quo_r[j] | (QUO_W'(1) << K);
        end else begin
          rem_r[j+1] <= rem_r[j];
          quo_r[j+1] <= quo_r[j];
        end
        dd_r[j+1]  <= dd_r[j];
        dfl_r[j+1] <= dfl_r[j];
      end
    end
  end

  // quadrant fold; q_up rounds a half up, q_dn rounds (-a) half up
  logic [BRG_W-1:0] q_up, q_dn, brg_nxt;
  quad_t            fl;

  always_comb begin
    fl   = dfl_r[QUO_W];
    q_up = BRG_W'(quo_r[QUO_W]);
    q_dn = q_up - BRG_W'(rem_r[QUO_W] == '0);
    if (fl.dy_zero) begin
      brg_nxt = fl.dx_neg ? BRG_LEFT : BRG_RIGHT;
    end else if (fl.dx_zero) begin
      brg_nxt = fl.dy_neg ? BRG_UP : BRG_DOWN;
    end else if (!fl.dx_neg && fl.dy_neg) begin
      brg_nxt = q_up;
    end else if (!fl.dx_neg) begin
      brg_nxt = BRG_DOWN - q_dn;
    end else if (!fl.dy_neg) begin
      brg_nxt = BRG_DOWN + q_up;
    end else begin
      brg_nxt = BRG_FULL - q_dn;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dist_r <= dd_r[QUO_W];
      out_brg_r  <= brg_nxt;
    end
  end

  assign out_res.valid       = out_v_r;
  assign out_res.dist_res    = out_dist_r;
  assign out_res.bearing_deg = out_brg_r;

endmodule

### sv/pdb_checker.sv
module pdb_checker import pdb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] dist_res,
  input logic [BRG_W-1:0]  bearing_deg
);

  // a stalled output word holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(dist_res) && $stable(bearing_deg))
    else $error("output word changed while stalled");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  // bearing never exceeds a full turn
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> bearing_deg <= BRG_FULL)
    else $error("bearing out of range");

  // identical points give zero distance and bearing right
  a_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dist_res == '0 |-> bearing_deg == BRG_RIGHT)
    else $error("zero distance with bearing other than right");

  // a taken output always frees the input side
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is taken");

endmodule

bind point_distance_and_bearing pdb_checker u_pdb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_pt.ready),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .dist_res   (out_res.dist_res),
  .bearing_deg(out_res.bearing_deg)
);
